// File: rtl/meinv_pkg.sv
// Shared widths, reset constant, command codes and types for the modular exponentiation block.
// Used by the RTL and its testbench; depends on nothing.
package meinv_pkg;

    localparam int MOD_BITS = 31;
    localparam int EXP_W    = 32;
    localparam int RES_W    = 31;
    localparam int CFG_W    = 31;
    localparam int CNT_W    = $clog2(EXP_W);

    localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(32'd3168257);

    // Operation carried by the cmd field of an input item.
    typedef enum logic {
        CMD_POW = 1'b0,
        CMD_INV = 1'b1
    } t_cmd;

    typedef logic [MOD_BITS-1:0] t_elem;
    typedef logic [EXP_W-1:0]    t_word;

    // One request to the shared modular multiplier: prod = a * b mod q.
    typedef struct packed {
        logic  start;
        t_elem a;
        t_word b;
    } t_mul_req;

endpackage

// File: rtl/meinv_mulmod.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on meinv_pkg for widths and the request struct.
module meinv_mulmod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  meinv_pkg::t_mul_req i_req,
    input  meinv_pkg::t_elem    i_mod,
    output logic                o_done,
    output meinv_pkg::t_elem    o_prod
);

    logic                        r_busy;
    logic                        r_done;
    logic [meinv_pkg::CNT_W-1:0] r_cnt;
    meinv_pkg::t_elem            r_acc;
    meinv_pkg::t_elem            r_a;
    meinv_pkg::t_word            r_b;

    logic [meinv_pkg::MOD_BITS+1:0] w_sum;
    logic [meinv_pkg::MOD_BITS+1:0] w_q1;
    logic [meinv_pkg::MOD_BITS+1:0] w_q2;
    meinv_pkg::t_elem               n_acc;
    logic                           w_last;

    // Each step doubles the accumulator and adds a when the multiplier bit is set.
    // With acc and a below q the sum stays below 3q, so one of two subtractions fixes it.
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0}
              + {2'b00, (r_b[meinv_pkg::EXP_W-1] ? r_a : '0)};
        w_q1  = {2'b00, i_mod};
        w_q2  = {1'b0, i_mod, 1'b0};
        if (w_sum >= w_q2) begin
            n_acc = meinv_pkg::MOD_BITS'(w_sum - w_q2);
        end else if (w_sum >= w_q1) begin
            n_acc = meinv_pkg::MOD_BITS'(w_sum - w_q1);
        end else begin
            n_acc = meinv_pkg::MOD_BITS'(w_sum);
        end
    end

    assign w_last = (r_cnt == meinv_pkg::CNT_W'(meinv_pkg::EXP_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[meinv_pkg::EXP_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiplier started while busy");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_last && !i_req.start) |=> (o_done && !r_busy))
        else $error("multiplier did not finish after its last step");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("multiplier done while still busy");
`endif

endmodule

// File: rtl/modular_exponentiation_inverse_top.sv
// Top level of the modular exponentiation and Fermat inverse block.
// Depends on meinv_pkg and instantiates the shared multiplier meinv_mulmod.
//
// Each accepted item (cmd, base, exponent) gives one result item in [0, q), where q is the
// modulus register. The signed base is reduced into [0, q) first, a negative remainder being
// corrected upward. With cmd 0 the block returns base^exponent mod q (exponent 0 gives 1);
// with cmd 1 it returns base^(q-2) mod q, the inverse when q is prime, and 0 for a base that
// reduces to zero. A modulus below two gives 0. All products, the reduction included, run through
// one bit-serial modular multiplier. Reduction is one pass through it, and each exponent bit takes a
// square, preceded by a multiply when the bit is set, so the time from acceptance to result depends on
// the exponent's bit length and its number of set bits. The block takes one item at a time and is
// not ready while it works; the finished result waits in an output register, and the next item may
// be accepted while it does. The modulus must be written through the write enable port only while
// the block is idle, which the block itself does not enforce; only its low MOD_BITS bits are kept.
module modular_exponentiation_inverse_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [meinv_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic signed [31:0]          i_base,
    input  logic [31:0]                 i_exponent,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [meinv_pkg::RES_W-1:0] o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_LOOP = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic             r_cmd, n_cmd;
    logic             r_neg, n_neg;
    meinv_pkg::t_word r_exp, n_exp;
    meinv_pkg::t_elem r_acc, n_acc;
    meinv_pkg::t_elem r_b, n_b;
    logic             r_out_valid;
    meinv_pkg::t_elem r_result;
    meinv_pkg::t_elem r_mod;

    logic                in_fire;
    logic                w_out_free;
    logic                w_mod_ok;
    meinv_pkg::t_word    w_base_u;
    meinv_pkg::t_word    w_mag;
    meinv_pkg::t_elem    w_fix;
    meinv_pkg::t_mul_req w_req;
    logic                w_done;
    meinv_pkg::t_elem    w_prod;

    assign o_ready    = (r_state == S_IDLE);
    assign in_fire    = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_mod_ok   = (r_mod >= meinv_pkg::MOD_BITS'(2));

    // Magnitude of the base; the most negative value maps to 2^31, which still fits.
    assign w_base_u = $unsigned(i_base);
    assign w_mag    = i_base[31] ? (~w_base_u + 32'd1) : w_base_u;

    // Reduction gives |base| mod q; a negative base with nonzero remainder becomes q - r.
    assign w_fix = (r_neg && (w_prod != '0)) ? (r_mod - w_prod) : w_prod;

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_neg   = r_neg;
        n_exp   = r_exp;
        n_acc   = r_acc;
        n_b     = r_b;
        w_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd = i_cmd;
                    n_neg = i_base[31];
                    n_exp = i_exponent;
                    if (w_mod_ok) begin
                        // Reduction reuses the multiplier as 1 * |base| mod q.
                        w_req.start = 1'b1;
                        w_req.a     = meinv_pkg::MOD_BITS'(1);
                        w_req.b     = w_mag;
                        n_state     = S_RED;
                    end else begin
                        n_acc   = '0;
                        n_state = S_FIN;
                    end
                end
            end
            S_RED: begin
                if (w_done) begin
                    n_b   = w_fix;
                    n_acc = meinv_pkg::MOD_BITS'(1);
                    if (r_cmd == meinv_pkg::CMD_INV) begin
                        n_exp = meinv_pkg::EXP_W'(r_mod - meinv_pkg::MOD_BITS'(2));
                    end
                    if (r_cmd == meinv_pkg::CMD_INV && w_fix == '0) begin
                        n_acc   = '0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                if (r_exp == '0) begin
                    n_state = S_FIN;
                end else begin
                    // A set bit multiplies the accumulator first, otherwise go straight to squaring.
                    w_req.start = 1'b1;
                    w_req.a     = r_exp[0] ? r_acc : r_b;
                    w_req.b     = meinv_pkg::EXP_W'(r_b);
                    n_state     = r_exp[0] ? S_MUL : S_SQR;
                end
            end
            S_MUL: begin
                if (w_done) begin
                    n_acc       = w_prod;
                    w_req.start = 1'b1;
                    w_req.a     = r_b;
                    w_req.b     = meinv_pkg::EXP_W'(r_b);
                    n_state     = S_SQR;
                end
            end
            S_SQR: begin
                if (w_done) begin
                    n_b     = w_prod;
                    n_exp   = {1'b0, r_exp[meinv_pkg::EXP_W-1:1]};
                    n_state = S_LOOP;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    meinv_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_mod   (r_mod),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mod       <= meinv_pkg::MOD_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_mod <= i_cfg_wr_data[meinv_pkg::MOD_BITS-1:0];
            end
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_neg <= n_neg;
        r_exp <= n_exp;
        r_acc <= n_acc;
        r_b   <= n_b;
        if (r_state == S_FIN && w_out_free) begin
            r_result <= r_acc;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = meinv_pkg::RES_W'(r_result);

`ifndef SYNTHESIS
    a_result_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && w_mod_ok) |-> (r_result < r_mod))
        else $error("result not reduced below the modulus");

    a_exp_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP && r_exp == '0) |=> (r_state == S_FIN))
        else $error("exponent exhausted but no result produced");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_RED || r_state == S_FIN))
        else $error("accepted item did not start reduction");
`endif

endmodule
